### rtl/expression_source_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tokenizer
// Each macro forms one labeled concurrent assertion clocked on clk.
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_SOURCE_TOKENIZER_ASSERT_SVH
`define EXPRESSION_SOURCE_TOKENIZER_ASSERT_SVH

// Same-cycle implication
`define ETOK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ETOK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/etok_pkg.sv
// ----------------------------------------------------------------------------
// etok_pkg
// Types, codes and character helpers shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package etok_pkg;

    localparam int MAX_STRING_BYTES = 1024;

    localparam logic [15:0] OFF_MAX   = 16'hFFFF;
    localparam logic [15:0] LINE_MAX  = 16'hFFFF;
    localparam logic [15:0] LEN_MAX   = 16'hFFFF;
    localparam logic [7:0]  DEPTH_MAX = 8'hFF;

    localparam logic       RES_TEXT   = 1'b0;
    localparam logic       RES_RECORD = 1'b1;

    localparam logic [2:0] KIND_EOF   = 3'd0;
    localparam logic [2:0] KIND_NUM   = 3'd1;
    localparam logic [2:0] KIND_IDENT = 3'd2;
    localparam logic [2:0] KIND_STR   = 3'd3;
    localparam logic [2:0] KIND_PUNCT = 3'd4;
    localparam logic [2:0] KIND_ERR   = 3'd5;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_UNTERM = 2'd1;
    localparam logic [1:0] ERR_UNEXP  = 2'd2;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_source;
    } src_item_t;

    typedef struct packed {
        logic        result_type;
        logic [7:0]  text_byte;
        logic [2:0]  token_kind;
        logic [15:0] start_offset;
        logic [15:0] token_length;
        logic [15:0] start_line;
        logic [1:0]  error_code;
        logic        last;
    } tok_item_t;

    typedef struct packed {
        logic active;
        logic hold_valid;
        logic hold_done;
    } etok_status_t;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z")) || (c == "_");
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_dig(c);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    // First byte of a possible two-character operator
    function automatic logic is_pair_lead(input logic [7:0] c);
        return (c == "<") || (c == ">") || (c == "=") || (c == "!") || (c == "&")
            || (c == "|") || (c == "+") || (c == "-") || (c == "*") || (c == "/")
            || (c == "%") || (c == "^");
    endfunction

    function automatic logic pair_ok(input logic [7:0] a, input logic [7:0] b);
        if ((a == "&") || (a == "|"))
            return b == a;
        return (b == "=") && (a != "&") && (a != "|") && is_pair_lead(a);
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        return is_pair_lead(c) || (c == "(") || (c == ")") || (c == "[") || (c == "]")
            || (c == "{") || (c == "}") || (c == ";") || (c == ",") || (c == "$")
            || (c == ".");
    endfunction

    // Bytes of the option-group opener after the leading hash
    function automatic logic [7:0] opt_char(input logic [2:0] k);
        logic [7:0] r;
        case (k)
            3'd1:    r = "o";
            3'd2:    r = "p";
            3'd3:    r = "t";
            3'd4:    r = "(";
            default: r = "#";
        endcase
        return r;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) ? (c - 8'd32) : c;
    endfunction

    function automatic logic [15:0] len_inc(input logic [15:0] x);
        return (x == LEN_MAX) ? x : (x + 16'd1);
    endfunction

    function automatic tok_item_t f_text(input logic [7:0] b);
        tok_item_t r;
        r = '0;
        r.result_type = RES_TEXT;
        r.text_byte   = b;
        return r;
    endfunction

    function automatic tok_item_t f_rec(input logic [2:0] kind, input logic [15:0] off,
                                        input logic [15:0] len, input logic [15:0] line,
                                        input logic [1:0] err);
        tok_item_t r;
        r = '0;
        r.result_type  = RES_RECORD;
        r.token_kind   = kind;
        r.start_offset = off;
        r.token_length = len;
        r.start_line   = line;
        r.error_code   = err;
        return r;
    endfunction

endpackage

### rtl/etok_front.sv
// ----------------------------------------------------------------------------
// etok_front
// Input side: takes source requests into a two-entry queue for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etok_front
    import etok_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  src_item_t src_item,
    output logic      q_valid,
    output src_item_t q_item,
    input  logic      q_pop
);

    src_item_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    // Ready from the registered fill level only
    assign src_ready = (cnt_reg != 2'd2);
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_item    = mem_reg[rd_ptr_reg];
    assign push      = src_valid && src_ready;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the request payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= src_item;
        end
    end

endmodule

### rtl/etok_outq.sv
// ----------------------------------------------------------------------------
// etok_outq
// Output side: four-entry result queue that absorbs bursts of results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etok_outq
    import etok_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tok_item_t push_item,
    output logic      space,
    output logic      tok_valid,
    input  logic      tok_ready,
    output tok_item_t tok_item
);

    tok_item_t  mem_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign space     = (cnt_reg != 3'd4);
    assign tok_valid = (cnt_reg != 3'd0);
    assign tok_item  = mem_reg[rd_ptr_reg];
    assign pop       = tok_valid && tok_ready;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + 2'd1) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + 2'd1) : rd_ptr_reg;
        cnt_next    = cnt_reg + {2'b00, push} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the result payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/etok_engine.sv
// ----------------------------------------------------------------------------
// etok_engine
// Lexer back end: holds a five-byte lookahead window and performs lexer actions,
// giving out one result per cycle while the output queue has space.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module etok_engine
    import etok_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  src_item_t    q_item,
    output logic         q_pop,
    input  logic         space,
    output logic         push,
    output tok_item_t    push_item,
    output etok_status_t status
);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_LINECMT = 4'd1;
    localparam logic [3:0] M_BLOCK   = 4'd2;
    localparam logic [3:0] M_OPT     = 4'd3;
    localparam logic [3:0] M_STR     = 4'd4;
    localparam logic [3:0] M_INT     = 4'd5;
    localparam logic [3:0] M_FRAC    = 4'd6;
    localparam logic [3:0] M_EXP     = 4'd7;
    localparam logic [3:0] M_HEX     = 4'd8;
    localparam logic [3:0] M_IDENT   = 4'd9;
    localparam logic [3:0] M_HALT    = 4'd10;

    // State
    logic [3:0]  mode_reg, mode_next;
    logic [7:0]  win_reg [5];
    logic [7:0]  win_next [5];
    logic [2:0]  wn_reg, wn_next;
    logic        at_end_reg, at_end_next;
    logic [15:0] off_reg, off_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] tso_reg, tso_next;
    logic [15:0] tsl_reg, tsl_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [7:0]  depth_reg, depth_next;
    logic        active_reg, active_next;
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  rcnt_reg, rcnt_next;
    tok_item_t   hold_reg, hold_next;
    logic        hold_valid_reg, hold_valid_next;
    logic        hold_done_reg, hold_done_next;

    // Window view
    logic        start;
    logic        run;
    logic [7:0]  w [5];
    logic [4:0]  av;
    logic [2:0]  vn;
    logic        vend;
    logic        wait0, gap0, wait1;

    // Option-group opener scan
    logic        hs_wait, hs_ok, hs_stop;

    // Action
    logic [3:0]  md_a;
    logic [2:0]  cons;
    logic [15:0] len_a;
    logic [7:0]  dep_a;
    logic        beg;
    logic        cont;
    logic        tail;
    logic [1:0]  ne;
    tok_item_t   e [3];

    // Sequencing
    logic        commit;
    logic        emit;
    logic        step_end;
    logic [16:0] off_sum;

    assign start = !active_reg && q_valid;
    assign run   = space && (active_reg || q_valid);
    assign q_pop = start && run;

    // Build the window with the incoming byte appended at step start
    always_comb
    begin
        vn   = wn_reg;
        vend = at_end_reg;
        for (int i = 0; i < 5; i++)
        begin
            w[i] = win_reg[i];
        end
        if (start)
        begin
            vend = q_item.end_of_source;
            if (!q_item.end_of_source)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    if (3'(i) == wn_reg)
                    begin
                        w[i] = q_item.ch;
                    end
                end
                vn = wn_reg + 3'd1;
            end
        end
        for (int i = 0; i < 5; i++)
        begin
            av[i] = (3'(i) < vn);
        end
        wait0 = !av[0] && !vend;
        gap0  = !av[0] && vend;
        wait1 = !av[1] && !vend;
    end

    // Scan for the option-group opener after a hash
    always_comb
    begin
        hs_wait = 1'b0;
        hs_ok   = 1'b1;
        hs_stop = 1'b0;
        for (int k = 1; k < 5; k++)
        begin
            if (!hs_stop)
            begin
                if (!av[k] && !vend)
                begin
                    hs_wait = 1'b1;
                    hs_stop = 1'b1;
                end
                else if (!av[k] || (w[k] != opt_char(3'(k))))
                begin
                    hs_ok   = 1'b0;
                    hs_stop = 1'b1;
                end
            end
        end
    end

    // Decide one lexer action
    always_comb
    begin
        md_a  = mode_reg;
        cons  = 3'd0;
        len_a = tlen_reg;
        dep_a = depth_reg;
        beg   = 1'b0;
        cont  = 1'b0;
        tail  = 1'b0;
        ne    = 2'd0;
        e[0]  = '0;
        e[1]  = '0;
        e[2]  = '0;
        if (!wait0)
        begin
            case (mode_reg)
                M_IDLE:
                begin
                    if (gap0)
                    begin
                        ne   = 2'd1;
                        e[0] = f_rec(KIND_EOF, off_reg, 16'd0, line_reg, ERR_NONE);
                    end
                    else if (is_blank(w[0]))
                    begin
                        cons = 3'd1;
                        cont = 1'b1;
                    end
                    else if ((w[0] == "/") && wait1)
                    begin
                        cont = 1'b0;
                    end
                    else if ((w[0] == "/") && av[1] && (w[1] == "/"))
                    begin
                        cons = 3'd2;
                        md_a = M_LINECMT;
                        cont = 1'b1;
                    end
                    else if ((w[0] == "/") && av[1] && (w[1] == "*"))
                    begin
                        cons = 3'd2;
                        md_a = M_BLOCK;
                        cont = 1'b1;
                    end
                    else if (w[0] == "#")
                    begin
                        if (hs_ok && !hs_wait)
                        begin
                            cons  = 3'd5;
                            dep_a = 8'd1;
                            md_a  = M_OPT;
                            cont  = 1'b1;
                        end
                        else if (!hs_wait)
                        begin
                            ne   = 2'd1;
                            e[0] = f_rec(KIND_ERR, off_reg, 16'd0, line_reg, ERR_UNEXP);
                            md_a = M_HALT;
                            cont = 1'b1;
                        end
                    end
                    else if (w[0] == "\"")
                    begin
                        beg   = 1'b1;
                        len_a = 16'd0;
                        cons  = 3'd1;
                        md_a  = M_STR;
                        cont  = 1'b1;
                    end
                    else if (is_dig(w[0]))
                    begin
                        if ((w[0] == "0") && wait1)
                        begin
                            cont = 1'b0;
                        end
                        else if ((w[0] == "0") && av[1] && ((w[1] == "x") || (w[1] == "X")))
                        begin
                            beg   = 1'b1;
                            ne    = 2'd2;
                            e[0]  = f_text(w[0]);
                            e[1]  = f_text(w[1]);
                            len_a = 16'd2;
                            cons  = 3'd2;
                            md_a  = M_HEX;
                            cont  = 1'b1;
                        end
                        else
                        begin
                            beg   = 1'b1;
                            len_a = 16'd0;
                            md_a  = M_INT;
                            cont  = 1'b1;
                        end
                    end
                    else if ((w[0] == ".") && wait1)
                    begin
                        cont = 1'b0;
                    end
                    else if ((w[0] == ".") && av[1] && is_dig(w[1]))
                    begin
                        beg   = 1'b1;
                        len_a = 16'd0;
                        md_a  = M_INT;
                        cont  = 1'b1;
                    end
                    else if (is_alpha(w[0]))
                    begin
                        beg   = 1'b1;
                        len_a = 16'd0;
                        md_a  = M_IDENT;
                        cont  = 1'b1;
                    end
                    else if (is_pair_lead(w[0]) && wait1)
                    begin
                        cont = 1'b0;
                    end
                    else if (is_pair_lead(w[0]) && av[1] && pair_ok(w[0], w[1]))
                    begin
                        beg   = 1'b1;
                        len_a = 16'd0;
                        ne    = 2'd3;
                        e[0]  = f_text(w[0]);
                        e[1]  = f_text(w[1]);
                        e[2]  = f_rec(KIND_PUNCT, off_reg, 16'd2, line_reg, ERR_NONE);
                        cons  = 3'd2;
                        cont  = 1'b1;
                    end
                    else if (is_single(w[0]))
                    begin
                        beg   = 1'b1;
                        len_a = 16'd0;
                        ne    = 2'd2;
                        e[0]  = f_text(w[0]);
                        e[1]  = f_rec(KIND_PUNCT, off_reg, 16'd1, line_reg, ERR_NONE);
                        cons  = 3'd1;
                        cont  = 1'b1;
                    end
                    else
                    begin
                        ne   = 2'd1;
                        e[0] = f_rec(KIND_ERR, off_reg, 16'd0, line_reg, ERR_UNEXP);
                        md_a = M_HALT;
                        cont = 1'b1;
                    end
                end
                M_LINECMT:
                begin
                    cont = 1'b1;
                    if (gap0 || (w[0] == 8'h0A))
                        md_a = M_IDLE;
                    else
                        cons = 3'd1;
                end
                M_BLOCK:
                begin
                    if (gap0)
                    begin
                        md_a = M_IDLE;
                        cont = 1'b1;
                    end
                    else if ((w[0] == "*") && wait1)
                    begin
                        cont = 1'b0;
                    end
                    else if ((w[0] == "*") && av[1] && (w[1] == "/"))
                    begin
                        cons = 3'd2;
                        md_a = M_IDLE;
                        cont = 1'b1;
                    end
                    else
                    begin
                        cons = 3'd1;
                        cont = 1'b1;
                    end
                end
                M_OPT:
                begin
                    cont = 1'b1;
                    if (gap0)
                    begin
                        md_a = M_IDLE;
                    end
                    else
                    begin
                        if ((w[0] == "(") && (depth_reg < DEPTH_MAX))
                            dep_a = depth_reg + 8'd1;
                        else if ((w[0] == ")") && (depth_reg > 8'd0))
                            dep_a = depth_reg - 8'd1;
                        cons = 3'd1;
                        if (dep_a == 8'd0)
                            md_a = M_IDLE;
                    end
                end
                M_STR:
                begin
                    if (gap0)
                    begin
                        ne   = 2'd1;
                        e[0] = f_rec(KIND_ERR, tso_reg, 16'd0, tsl_reg, ERR_UNTERM);
                        md_a = M_HALT;
                        cont = 1'b1;
                    end
                    else if (w[0] == "\"")
                    begin
                        ne   = 2'd1;
                        e[0] = f_rec(KIND_STR, tso_reg, tlen_reg, tsl_reg, ERR_NONE);
                        cons = 3'd1;
                        md_a = M_IDLE;
                        cont = 1'b1;
                    end
                    else if ((w[0] == "\\") && wait1)
                    begin
                        cont = 1'b0;
                    end
                    else
                    begin
                        cont = 1'b1;
                        if ((w[0] == "\\") && av[1] && (w[1] == "\""))
                        begin
                            cons = 3'd2;
                            e[0] = f_text("\"");
                        end
                        else
                        begin
                            cons = 3'd1;
                            e[0] = f_text(w[0]);
                        end
                        // Keep only the first bytes of a long string
                        if (tlen_reg < 16'(MAX_STRING_BYTES))
                        begin
                            ne    = 2'd1;
                            len_a = tlen_reg + 16'd1;
                        end
                    end
                end
                M_INT, M_FRAC:
                begin
                    if (av[0] && is_dig(w[0]))
                    begin
                        ne    = 2'd1;
                        e[0]  = f_text(w[0]);
                        len_a = len_inc(tlen_reg);
                        cons  = 3'd1;
                        cont  = 1'b1;
                    end
                    else if ((mode_reg == M_INT) && av[0] && (w[0] == "."))
                    begin
                        ne    = 2'd1;
                        e[0]  = f_text(w[0]);
                        len_a = len_inc(tlen_reg);
                        cons  = 3'd1;
                        md_a  = M_FRAC;
                        cont  = 1'b1;
                    end
                    else
                    begin
                        tail = 1'b1;
                    end
                end
                M_EXP, M_HEX:
                begin
                    cont = 1'b1;
                    if (av[0] && ((mode_reg == M_EXP) ? is_dig(w[0]) : is_hex(w[0])))
                    begin
                        ne    = 2'd1;
                        e[0]  = f_text(w[0]);
                        len_a = len_inc(tlen_reg);
                        cons  = 3'd1;
                    end
                    else
                    begin
                        ne   = 2'd1;
                        e[0] = f_rec(KIND_NUM, tso_reg, tlen_reg, tsl_reg, ERR_NONE);
                        md_a = M_IDLE;
                    end
                end
                M_IDENT:
                begin
                    cont = 1'b1;
                    if (av[0] && is_word(w[0]))
                    begin
                        ne    = 2'd1;
                        e[0]  = f_text(to_upper(w[0]));
                        len_a = len_inc(tlen_reg);
                        cons  = 3'd1;
                    end
                    else
                    begin
                        ne   = 2'd1;
                        e[0] = f_rec(KIND_IDENT, tso_reg, tlen_reg, tsl_reg, ERR_NONE);
                        md_a = M_IDLE;
                    end
                end
                default:
                begin
                    // Halted after an error: drop bytes until end of source
                    if (!gap0)
                    begin
                        cons = 3'd1;
                        cont = 1'b1;
                    end
                end
            endcase

            // Number end: look for an exponent, else close the number
            if (tail)
            begin
                cont = 1'b1;
                if (av[0] && ((w[0] == "e") || (w[0] == "E")) && wait1)
                begin
                    cont = 1'b0;
                end
                else if (av[0] && ((w[0] == "e") || (w[0] == "E")) && av[1]
                         && ((w[1] == "+") || (w[1] == "-")) && !av[2] && !vend)
                begin
                    cont = 1'b0;
                end
                else if (av[0] && ((w[0] == "e") || (w[0] == "E")) && av[1]
                         && ((w[1] == "+") || (w[1] == "-")) && av[2] && is_dig(w[2]))
                begin
                    ne    = 2'd2;
                    e[0]  = f_text(w[0]);
                    e[1]  = f_text(w[1]);
                    len_a = len_inc(len_inc(tlen_reg));
                    cons  = 3'd2;
                    md_a  = M_EXP;
                end
                else if (av[0] && ((w[0] == "e") || (w[0] == "E")) && av[1] && is_dig(w[1]))
                begin
                    ne    = 2'd1;
                    e[0]  = f_text(w[0]);
                    len_a = len_inc(tlen_reg);
                    cons  = 3'd1;
                    md_a  = M_EXP;
                end
                else
                begin
                    ne   = 2'd1;
                    e[0] = f_rec(KIND_NUM, tso_reg, tlen_reg, tsl_reg, ERR_NONE);
                    md_a = M_IDLE;
                end
            end
        end
    end

    // Sequence results of one action, one per cycle while the output queue has space
    assign commit   = run && ((ne == 2'd0) || (phase_reg == (ne - 2'd1)));
    assign emit     = run && (ne != 2'd0) && (rcnt_reg < 4'd8);
    assign step_end = commit && !cont;
    assign off_sum  = {1'b0, off_reg} + {14'd0, cons};

    // Forward the held result once its successor or the step end is known
    always_comb
    begin
        push      = space && hold_valid_reg && (hold_done_reg || emit || step_end);
        push_item = hold_reg;
        push_item.last = hold_reg.last | (step_end && !emit);
    end

    // Next state
    always_comb
    begin
        mode_next       = mode_reg;
        wn_next         = wn_reg;
        at_end_next     = at_end_reg;
        off_next        = off_reg;
        line_next       = line_reg;
        tso_next        = tso_reg;
        tsl_next        = tsl_reg;
        tlen_next       = tlen_reg;
        depth_next      = depth_reg;
        active_next     = active_reg;
        phase_next      = phase_reg;
        rcnt_next       = rcnt_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        hold_done_next  = hold_done_reg;
        for (int i = 0; i < 5; i++)
        begin
            win_next[i] = win_reg[i];
        end

        if (run)
        begin
            // Latch the window view
            for (int i = 0; i < 5; i++)
            begin
                win_next[i] = w[i];
            end
            wn_next     = vn;
            at_end_next = vend;
            active_next = 1'b1;
            if (emit)
            begin
                rcnt_next = rcnt_reg + 4'd1;
            end
            if (!commit)
            begin
                phase_next = phase_reg + 2'd1;
            end
            else
            begin
                phase_next = 2'd0;
                mode_next  = md_a;
                tlen_next  = len_a;
                depth_next = dep_a;
                if (beg)
                begin
                    tso_next = off_reg;
                    tsl_next = line_reg;
                end
                // Consume bytes: shift the window and advance position
                for (int i = 0; i < 5; i++)
                begin
                    win_next[i] = 8'h00;
                    for (int j = 0; j < 5; j++)
                    begin
                        if (4'(j) == (4'(i) + {1'b0, cons}))
                        begin
                            win_next[i] = w[j];
                        end
                    end
                end
                wn_next  = (cons > vn) ? 3'd0 : (vn - cons);
                off_next = (off_sum > {1'b0, OFF_MAX}) ? OFF_MAX : off_sum[15:0];
                if ((cons == 3'd1) && (w[0] == 8'h0A) && (line_reg < LINE_MAX))
                begin
                    line_next = line_reg + 16'd1;
                end
                if (step_end)
                begin
                    active_next = 1'b0;
                    rcnt_next   = 4'd0;
                    if (vend)
                    begin
                        mode_next  = M_IDLE;
                        wn_next    = 3'd0;
                        off_next   = 16'd0;
                        line_next  = 16'd1;
                        tso_next   = 16'd0;
                        tsl_next   = 16'd1;
                        tlen_next  = 16'd0;
                        depth_next = 8'd0;
                    end
                    else if (wn_next > 3'd4)
                    begin
                        wn_next = 3'd4;
                    end
                    at_end_next = 1'b0;
                end
            end
        end

        // Hold stage
        if (emit)
        begin
            hold_next       = e[phase_reg];
            hold_next.last  = step_end;
            hold_valid_next = 1'b1;
            hold_done_next  = step_end;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
            hold_done_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_IDLE;
            wn_reg         <= 3'd0;
            at_end_reg     <= 1'b0;
            off_reg        <= 16'd0;
            line_reg       <= 16'd1;
            tso_reg        <= 16'd0;
            tsl_reg        <= 16'd1;
            tlen_reg       <= 16'd0;
            depth_reg      <= 8'd0;
            active_reg     <= 1'b0;
            phase_reg      <= 2'd0;
            rcnt_reg       <= 4'd0;
            hold_valid_reg <= 1'b0;
            hold_done_reg  <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            wn_reg         <= wn_next;
            at_end_reg     <= at_end_next;
            off_reg        <= off_next;
            line_reg       <= line_next;
            tso_reg        <= tso_next;
            tsl_reg        <= tsl_next;
            tlen_reg       <= tlen_next;
            depth_reg      <= depth_next;
            active_reg     <= active_next;
            phase_reg      <= phase_next;
            rcnt_reg       <= rcnt_next;
            hold_valid_reg <= hold_valid_next;
            hold_done_reg  <= hold_done_next;
        end
    end

    // Window bytes and held result carry no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 5; i++)
        begin
            win_reg[i] <= win_next[i];
        end
        hold_reg <= hold_next;
    end

    assign status.active     = active_reg;
    assign status.hold_valid = hold_valid_reg;
    assign status.hold_done  = hold_done_reg;

endmodule

### rtl/expression_source_tokenizer.sv
// An accepted request passes the input queue, the engine's hold register and the output
// queue before its results reach tok_item; further results of the request follow in order.
// The engine performs lexer actions, issues the results of an action one after another and
// ends a request on finding the window dry; it takes the next request only after that end.
// Lookahead bytes wait in a five-byte window until the next bytes settle their role.
// Reset: asynchronous, active low; clears queues and returns to line 1, offset 0.
// ----------------------------------------------------------------------------
// expression_source_tokenizer
// Streaming tokenizer: input queue, lexer engine and output result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "expression_source_tokenizer_assert.svh"

module expression_source_tokenizer
    import etok_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  src_item_t src_item,
    output logic      tok_valid,
    input  logic      tok_ready,
    output tok_item_t tok_item
);

    logic         q_valid;
    src_item_t    q_item;
    logic         q_pop;
    logic         space;
    logic         push;
    tok_item_t    push_item;
    etok_status_t status;

    // Accept source requests
    etok_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // Lex the byte stream
    etok_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .space     (space),
        .push      (push),
        .push_item (push_item),
        .status    (status)
    );

    // Buffer results
    etok_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .space     (space),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_item  (tok_item)
    );

    `ETOK_ASSERT_NOW(a_done_needs_hold, status.hold_done, status.hold_valid, "final result flagged without held result")
    `ETOK_ASSERT_NEXT(a_accept_queued, src_valid && src_ready, q_valid, "accepted request missing from queue")
    `ETOK_ASSERT_NOW(a_text_clean, tok_valid && (tok_item.result_type == RES_TEXT), (tok_item.token_kind == KIND_EOF) && (tok_item.error_code == ERR_NONE), "text byte carries record fields")

endmodule
